@@ rtl/core/affr_pkg.sv @@
// Shared types and constants for the address-flagged frame receiver.
`default_nettype none

package affr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_STATUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MEASURE = 1'b1;

    localparam logic FRAME_KIND_STATUS  = 1'b0;
    localparam logic FRAME_KIND_MEASURE = 1'b1;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'b001,
        KIND_STATUS  = 3'b010,
        KIND_MEASURE = 3'b100
    } open_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              is_address;
    } rx_item_t;

    typedef struct packed {
        logic              frame_kind;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
        logic              checksum_good;
    } frame_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_code_status;
        logic [BYTE_W-1:0] header_code_measure;
    } header_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/affr_if.sv @@
// Valid/ready channel interfaces for received bytes and decoded frames.
`default_nettype none

interface affr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       is_address;

    modport source (output valid, output rx_byte, output is_address, input ready);
    modport sink   (input valid, input rx_byte, input is_address, output ready);
endinterface

interface affr_frame_if;
    logic        valid;
    logic        ready;
    logic        frame_kind;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic        checksum_good;

    modport source (output valid, output frame_kind, output first_word,
                    output second_word, output checksum_good, input ready);
    modport sink   (input valid, input frame_kind, input first_word,
                    input second_word, input checksum_good, output ready);
endinterface

`default_nettype wire

@@ rtl/core/address_flagged_frame_receiver.sv @@
// A frame's result is written to the result register once its checksum byte leaves the input register.
// Throughput: one byte transaction per cycle while the result side takes results.
// Each byte passes an input register, then one pass of compare, add and select
// into the result register; while a result waits, one more byte can enter the input register.
// Reset: rst_n clears both header codes to zero, closes any open frame and
// empties the input and result registers.
`default_nettype none

module address_flagged_frame_receiver
    import affr_pkg::*;
#(
    parameter int unsigned FRAME_LENGTH = 6
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    affr_rx_if.sink                   rx,
    affr_frame_if.source              frame
);

    header_cfg_t hdr_cfg_reg;
    logic        in_valid_reg;
    rx_item_t    in_item_reg;
    logic        out_valid_reg, out_valid_next;
    frame_item_t out_item_reg;
    logic        advance;
    logic        emit;
    frame_item_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_STATUS:  hdr_cfg_reg.header_code_status  <= cfg_data;
                CFG_HEADER_MEASURE: hdr_cfg_reg.header_code_measure <= cfg_data;
                default:            hdr_cfg_reg <= hdr_cfg_reg;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || frame.ready);
    assign rx.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_item_reg.rx_byte    <= rx.rx_byte;
            in_item_reg.is_address <= rx.is_address;
        end
    end

    affr_frame_engine #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (in_item_reg),
        .hdr_cfg (hdr_cfg_reg),
        .emit    (emit),
        .result  (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_item_reg <= result;
        end
    end

    assign frame.valid         = out_valid_reg;
    assign frame.frame_kind    = out_item_reg.frame_kind;
    assign frame.first_word    = out_item_reg.first_word;
    assign frame.second_word   = out_item_reg.second_word;
    assign frame.checksum_good = out_item_reg.checksum_good;

endmodule

`default_nettype wire

@@ rtl/core/affr_frame_engine.sv @@
// Frame state tracking, byte capture, running checksum and result formation.
`default_nettype none

module affr_frame_engine
    import affr_pkg::*;
#(
    parameter int unsigned FRAME_LENGTH = 6
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire rx_item_t    item,
    input  wire header_cfg_t hdr_cfg,
    output logic             emit,
    output frame_item_t      result
);

    localparam int unsigned CNT_W = $clog2(FRAME_LENGTH);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LENGTH - 1);
    localparam int unsigned POS_W = 5;

    open_kind_t        kind_reg, kind_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] word_bytes_reg [1:4];
    logic [BYTE_W-1:0] word_bytes_out [1:4];
    logic              hit_status;
    logic              hit_measure;
    logic              store_data;

    assign hit_status  = item.is_address && (item.rx_byte == hdr_cfg.header_code_status);
    assign hit_measure = item.is_address && !hit_status
                         && (item.rx_byte == hdr_cfg.header_code_measure);

    always_comb
    begin
        kind_next  = kind_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        emit       = 1'b0;
        store_data = 1'b0;
        if (step)
        begin
            if (item.is_address)
            begin
                if (hit_status || hit_measure)
                begin
                    kind_next  = hit_status ? KIND_STATUS : KIND_MEASURE;
                    count_next = CNT_W'(1);
                    sum_next   = item.rx_byte;
                end
            end
            else
            begin
                unique case (kind_reg)
                    KIND_NONE:
                    begin
                        kind_next = KIND_NONE;
                    end
                    KIND_STATUS, KIND_MEASURE:
                    begin
                        if (count_reg != LAST_POS)
                        begin
                            store_data = 1'b1;
                            sum_next   = sum_reg + item.rx_byte;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            emit       = 1'b1;
                            kind_next  = KIND_NONE;
                            count_next = '0;
                        end
                    end
                    default:
                    begin
                        kind_next  = KIND_NONE;
                        count_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_NONE;
            count_reg <= '0;
        end
        else
        begin
            kind_reg  <= kind_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    for (genvar p = 1; p <= 4; p++)
    begin : g_word_byte
        localparam bit KEEP = (p < FRAME_LENGTH - 1);

        always_ff @(posedge clk)
        begin
            if (KEEP && store_data && (POS_W'(count_reg) == POS_W'(p)))
            begin
                word_bytes_reg[p] <= item.rx_byte;
            end
        end

        assign word_bytes_out[p] = KEEP ? word_bytes_reg[p] : '0;
    end

    assign result.frame_kind    = (kind_reg == KIND_MEASURE) ? FRAME_KIND_MEASURE
                                                             : FRAME_KIND_STATUS;
    assign result.first_word    = {word_bytes_out[1], word_bytes_out[2]};
    assign result.second_word   = {word_bytes_out[3], word_bytes_out[4]};
    assign result.checksum_good = (item.rx_byte == ~sum_reg);

endmodule

`default_nettype wire
